// ===== hw/rtl/carrier_tracking_pll_defines.svh =====
// ----------------------------------------------------------------------------
// Carrier tracking PLL assertion macros
// Shared assertion forms for the carrier tracking PLL. Each macro expects
// signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef CARRIER_TRACKING_PLL_DEFINES_SVH
`define CARRIER_TRACKING_PLL_DEFINES_SVH

// Consequent must hold on the clock edge after the antecedent.
`define CTPLL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold on the same clock edge as the antecedent.
`define CTPLL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ctpll_pkg.sv =====
// ----------------------------------------------------------------------------
// Carrier tracking PLL package
// Widths, CORDIC constants, register indexes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctpll_pkg;

    // Data widths.
    localparam int PHASE_BITS   = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int GAIN_BITS    = 16;
    localparam int LIMIT_BITS   = 15;
    localparam int FREQ_BITS    = 16;
    localparam int TRIG_BITS    = 16;
    localparam int DEMOD_BITS   = 17;

    // CORDIC settings. Angles are 32-bit fractions of a turn.
    localparam int CORDIC_STEPS  = 16;
    localparam int ANGLE_BITS    = 32;
    localparam int VEC_PRESHIFT  = 8;
    localparam int VEC_BITS      = SAMPLE_BITS + VEC_PRESHIFT + 3;
    localparam int ROT_BITS      = 33;
    localparam int ROT_Z_BITS    = ANGLE_BITS + 2;
    localparam int TRIG_FRAC     = 15;

    localparam logic signed [ROT_BITS-1:0] ROT_START = ROT_BITS'(652032874);
    localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] PHASE_ROUND =
        ANGLE_BITS'(1) << (ANGLE_BITS - 1 - PHASE_BITS);

    // Configuration port.
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    localparam logic [REG_IDX_BITS-1:0] REG_PHASE_GAIN     = REG_IDX_BITS'(0);
    localparam logic [REG_IDX_BITS-1:0] REG_FREQ_GAIN      = REG_IDX_BITS'(1);
    localparam logic [REG_IDX_BITS-1:0] REG_MAX_FREQ_OFFSET = REG_IDX_BITS'(2);

    localparam logic [GAIN_BITS-1:0]  PHASE_GAIN_RESET      = GAIN_BITS'(3277);
    localparam logic [GAIN_BITS-1:0]  FREQ_GAIN_RESET       = GAIN_BITS'(41);
    localparam logic [LIMIT_BITS-1:0] MAX_FREQ_OFFSET_RESET = LIMIT_BITS'(5215);

    // One complex sample; i sits in the low half when packed.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] q;
        logic signed [SAMPLE_BITS-1:0] i;
    } sample_t;

    // Loop configuration.
    typedef struct packed {
        logic [GAIN_BITS-1:0]  phase_gain;
        logic [GAIN_BITS-1:0]  freq_gain;
        logic [LIMIT_BITS-1:0] max_freq_offset;
    } cfg_t;

    // Oscillator state.
    typedef struct packed {
        logic [PHASE_BITS-1:0]        phase;
        logic signed [FREQ_BITS-1:0]  freq;
    } loop_state_t;

    // Arctangent of 2^-k as a 32-bit fraction of a turn.
    function automatic logic [ANGLE_BITS-1:0] cordic_angle(input int unsigned k);
        logic [ANGLE_BITS-1:0] a;
        case (k)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/ctpll_vector.sv =====
// ----------------------------------------------------------------------------
// Carrier tracking PLL sample angle pipeline
// Registers the incoming sample and finds its angle with a pipelined CORDIC
// vectoring unit, one micro-rotation per stage, rounded to the phase width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctpll_vector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  ctpll_pkg::sample_t                  in_sample,
    output logic                                out_valid,
    output logic [ctpll_pkg::PHASE_BITS-1:0]    out_angle,
    output ctpll_pkg::sample_t                  out_sample
);

    localparam int N  = ctpll_pkg::CORDIC_STEPS;
    localparam int VB = ctpll_pkg::VEC_BITS;
    localparam int AB = ctpll_pkg::ANGLE_BITS;
    localparam int PB = ctpll_pkg::PHASE_BITS;

    logic                   in_valid_reg;
    ctpll_pkg::sample_t     in_sample_reg;

    logic signed [VB-1:0]   x_fold;
    logic signed [VB-1:0]   y_fold;
    logic [AB-1:0]          z_fold;
    logic                   zero_fold;

    logic signed [VB-1:0]   x_cur [N];
    logic signed [VB-1:0]   y_cur [N];
    logic [AB-1:0]          z_cur [N];
    logic signed [VB-1:0]   x_next [N];
    logic signed [VB-1:0]   y_next [N];
    logic [AB-1:0]          z_next [N];

    logic signed [VB-1:0]   x_reg [N];
    logic signed [VB-1:0]   y_reg [N];
    logic [AB-1:0]          z_reg [N];
    logic [N-1:0]           zero_reg;
    logic [N-1:0]           vld_reg;
    ctpll_pkg::sample_t     smp_reg [N];

    logic [AB-1:0]          z_round;
    logic [PB-1:0]          angle_next;

    logic                   out_valid_reg;
    logic [PB-1:0]          out_angle_reg;
    ctpll_pkg::sample_t     out_sample_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_sample_reg <= in_sample;
        end
    end

    // Scale up and fold the left half-plane onto the right by half a turn.
    always_comb
    begin
        x_fold    = VB'(in_sample_reg.i) <<< ctpll_pkg::VEC_PRESHIFT;
        y_fold    = VB'(in_sample_reg.q) <<< ctpll_pkg::VEC_PRESHIFT;
        z_fold    = '0;
        zero_fold = (in_sample_reg.i == '0) && (in_sample_reg.q == '0);
        if (x_fold < 0)
        begin
            x_fold = -x_fold;
            y_fold = -y_fold;
            z_fold = ctpll_pkg::HALF_TURN;
        end
    end

    // One micro-rotation per stage, steering y toward zero.
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                x_cur[k] = x_fold;
                y_cur[k] = y_fold;
                z_cur[k] = z_fold;
            end
            else
            begin
                x_cur[k] = x_reg[k-1];
                y_cur[k] = y_reg[k-1];
                z_cur[k] = z_reg[k-1];
            end
            if (y_cur[k] > 0)
            begin
                x_next[k] = x_cur[k] + (y_cur[k] >>> k);
                y_next[k] = y_cur[k] - (x_cur[k] >>> k);
                z_next[k] = z_cur[k] + ctpll_pkg::cordic_angle(k);
            end
            else
            begin
                x_next[k] = x_cur[k] - (y_cur[k] >>> k);
                y_next[k] = y_cur[k] + (x_cur[k] >>> k);
                z_next[k] = z_cur[k] - ctpll_pkg::cordic_angle(k);
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid_reg};
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
            zero_reg   <= {zero_reg[N-2:0], zero_fold};
            smp_reg[0] <= in_sample_reg;
            for (int k = 1; k < N; k++)
            begin
                smp_reg[k] <= smp_reg[k-1];
            end
        end
    end

    // Round the angle half up to the phase width; a zero sample has angle zero.
    always_comb
    begin
        z_round    = z_reg[N-1] + ctpll_pkg::PHASE_ROUND;
        angle_next = zero_reg[N-1] ? '0 : z_round[AB-1 -: PB];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_angle_reg  <= angle_next;
            out_sample_reg <= smp_reg[N-1];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_angle  = out_angle_reg;
    assign out_sample = out_sample_reg;

endmodule

// ===== hw/rtl/ctpll_loop.sv =====
// ----------------------------------------------------------------------------
// Carrier tracking PLL loop filter
// Holds oscillator phase and frequency. For each word it forms the phase
// error, updates the clipped frequency and advances the phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctpll_loop (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [ctpll_pkg::PHASE_BITS-1:0]    in_angle,
    input  ctpll_pkg::sample_t                  in_sample,
    input  ctpll_pkg::cfg_t                     cfg,
    output logic                                out_valid,
    output logic [ctpll_pkg::PHASE_BITS-1:0]    out_phase,
    output ctpll_pkg::sample_t                  out_sample,
    output ctpll_pkg::loop_state_t              state
);

    localparam int PB = ctpll_pkg::PHASE_BITS;
    localparam int GB = ctpll_pkg::GAIN_BITS;
    localparam int FB = ctpll_pkg::FREQ_BITS;
    localparam int PW = PB + GB + 1;
    localparam int FSUM_W = ((FB > PB + 1) ? FB : PB + 1) + 1;
    localparam logic signed [PW-1:0] GAIN_HALF = PW'(1) << (GB - 1);

    logic [PB-1:0]              phase_reg;
    logic signed [FB-1:0]       freq_reg;
    logic [PB-1:0]              phase_next;
    logic signed [FB-1:0]       freq_next;

    logic signed [PB-1:0]       err;
    logic signed [PW-1:0]       fprod;
    logic signed [PW-1:0]       pprod;
    logic signed [PW-1:0]       fround;
    logic signed [PW-1:0]       pround;
    logic signed [PB:0]         fstep;
    logic signed [PB:0]         pstep;
    logic signed [FSUM_W-1:0]   fsum;
    logic signed [FSUM_W-1:0]   lim;
    logic signed [FSUM_W-1:0]   fclip;

    logic                       out_valid_reg;
    logic [PB-1:0]              out_phase_reg;
    ctpll_pkg::sample_t         out_sample_reg;

    // Phase error wraps to a signed half turn; exactly half a turn is negative.
    always_comb
    begin
        err    = $signed(in_angle - phase_reg);
        fprod  = err * $signed({1'b0, cfg.freq_gain});
        pprod  = err * $signed({1'b0, cfg.phase_gain});
        fround = fprod + GAIN_HALF;
        pround = pprod + GAIN_HALF;
        fstep  = $signed(fround[PW-1:GB]);
        pstep  = $signed(pround[PW-1:GB]);
    end

    // Frequency integrates the error and clips to the configured limit.
    always_comb
    begin
        lim  = $signed(FSUM_W'(cfg.max_freq_offset));
        fsum = FSUM_W'(freq_reg) + FSUM_W'(fstep);
        if (fsum > lim)
        begin
            fclip = lim;
        end
        else if (fsum < -lim)
        begin
            fclip = -lim;
        end
        else
        begin
            fclip = fsum;
        end
        freq_next  = FB'(fclip);
        phase_next = phase_reg + pstep[PB-1:0] + PB'(fclip);
    end

    // Oscillator state moves only when a word passes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            freq_reg  <= '0;
        end
        else if (en && in_valid)
        begin
            phase_reg <= phase_next;
            freq_reg  <= freq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // The word leaves with the phase it was measured against.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_phase_reg  <= phase_reg;
            out_sample_reg <= in_sample;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_phase   = out_phase_reg;
    assign out_sample  = out_sample_reg;
    assign state.phase = phase_reg;
    assign state.freq  = freq_reg;

endmodule

// ===== hw/rtl/ctpll_rotator.sv =====
// ----------------------------------------------------------------------------
// Carrier tracking PLL derotator
// Pipelined CORDIC rotator for cosine and sine of the oscillator phase,
// followed by the product and rounding stages of the demodulated value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctpll_rotator (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic [ctpll_pkg::PHASE_BITS-1:0]        in_phase,
    input  ctpll_pkg::sample_t                      in_sample,
    output logic                                    out_valid,
    output logic signed [ctpll_pkg::DEMOD_BITS-1:0] out_demod
);

    localparam int N  = ctpll_pkg::CORDIC_STEPS;
    localparam int RB = ctpll_pkg::ROT_BITS;
    localparam int ZB = ctpll_pkg::ROT_Z_BITS;
    localparam int AB = ctpll_pkg::ANGLE_BITS;
    localparam int PB = ctpll_pkg::PHASE_BITS;
    localparam int SB = ctpll_pkg::SAMPLE_BITS;
    localparam int TB = ctpll_pkg::TRIG_BITS;
    localparam int DB = ctpll_pkg::DEMOD_BITS;
    localparam int TF = ctpll_pkg::TRIG_FRAC;
    localparam int RW = RB + 1;
    localparam int MW = SB + TB;
    localparam int DW = MW + 2;

    localparam logic signed [RW-1:0] T_HALF = RW'(1) << (TF - 1);
    localparam logic signed [RW-1:0] T_MAX  = RW'((1 << (TB - 1)) - 1);
    localparam logic signed [RW-1:0] T_MIN  = -RW'(1 << (TB - 1));
    localparam logic signed [DW-1:0] D_HALF = DW'(1) << (TF - 1);
    localparam logic signed [DW-1:0] D_MAX  = DW'((1 << (DB - 1)) - 1);
    localparam logic signed [DW-1:0] D_MIN  = -DW'(1 << (DB - 1));

    logic [AB-1:0]          z_raw;
    logic                   flip_in;
    logic signed [ZB-1:0]   z_fold;

    logic signed [RB-1:0]   x_cur [N];
    logic signed [RB-1:0]   y_cur [N];
    logic signed [ZB-1:0]   z_cur [N];
    logic signed [RB-1:0]   x_next [N];
    logic signed [RB-1:0]   y_next [N];
    logic signed [ZB-1:0]   z_next [N];

    logic signed [RB-1:0]   x_reg [N];
    logic signed [RB-1:0]   y_reg [N];
    logic signed [ZB-1:0]   z_reg [N];
    logic [N-1:0]           flip_reg;
    logic [N-1:0]           vld_reg;
    ctpll_pkg::sample_t     smp_reg [N];

    logic signed [RW-1:0]   xw;
    logic signed [RW-1:0]   yw;
    logic signed [RW-1:0]   xr;
    logic signed [RW-1:0]   yr;
    logic signed [TB-1:0]   cos_next;
    logic signed [TB-1:0]   sin_next;

    logic                   trig_valid_reg;
    logic signed [TB-1:0]   cos_reg;
    logic signed [TB-1:0]   sin_reg;
    ctpll_pkg::sample_t     trig_sample_reg;

    logic                   prod_valid_reg;
    logic signed [MW-1:0]   qc_reg;
    logic signed [MW-1:0]   is_reg;

    logic signed [DW-1:0]   dsum;
    logic signed [DW-1:0]   dshift;
    logic signed [DB-1:0]   demod_next;

    logic                   out_valid_reg;
    logic signed [DB-1:0]   out_demod_reg;

    // Fold the second and third quadrants by half a turn.
    always_comb
    begin
        z_raw   = {in_phase, (AB - PB)'(0)};
        flip_in = z_raw[AB-1] ^ z_raw[AB-2];
        if (flip_in)
        begin
            z_raw[AB-1] = ~z_raw[AB-1];
        end
        z_fold = ZB'($signed(z_raw));
    end

    // One micro-rotation per stage, driving the residual angle to zero.
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                x_cur[k] = ctpll_pkg::ROT_START;
                y_cur[k] = '0;
                z_cur[k] = z_fold;
            end
            else
            begin
                x_cur[k] = x_reg[k-1];
                y_cur[k] = y_reg[k-1];
                z_cur[k] = z_reg[k-1];
            end
            if (z_cur[k] >= 0)
            begin
                x_next[k] = x_cur[k] - (y_cur[k] >>> k);
                y_next[k] = y_cur[k] + (x_cur[k] >>> k);
                z_next[k] = z_cur[k] - $signed(ZB'(ctpll_pkg::cordic_angle(k)));
            end
            else
            begin
                x_next[k] = x_cur[k] + (y_cur[k] >>> k);
                y_next[k] = y_cur[k] - (x_cur[k] >>> k);
                z_next[k] = z_cur[k] + $signed(ZB'(ctpll_pkg::cordic_angle(k)));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
            flip_reg   <= {flip_reg[N-2:0], flip_in};
            smp_reg[0] <= in_sample;
            for (int k = 1; k < N; k++)
            begin
                smp_reg[k] <= smp_reg[k-1];
            end
        end
    end

    // Undo the fold, round half up to Q1.15 and saturate.
    always_comb
    begin
        xw = flip_reg[N-1] ? -RW'(x_reg[N-1]) : RW'(x_reg[N-1]);
        yw = flip_reg[N-1] ? -RW'(y_reg[N-1]) : RW'(y_reg[N-1]);
        xr = (xw + T_HALF) >>> TF;
        yr = (yw + T_HALF) >>> TF;
        if (xr > T_MAX)
        begin
            cos_next = TB'(T_MAX);
        end
        else if (xr < T_MIN)
        begin
            cos_next = TB'(T_MIN);
        end
        else
        begin
            cos_next = TB'(xr);
        end
        if (yr > T_MAX)
        begin
            sin_next = TB'(T_MAX);
        end
        else if (yr < T_MIN)
        begin
            sin_next = TB'(T_MIN);
        end
        else
        begin
            sin_next = TB'(yr);
        end
    end

    // Valid bits of the trig, product and result stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            trig_valid_reg <= vld_reg[N-1];
            prod_valid_reg <= trig_valid_reg;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    // Trig values and the two products, each behind its own register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg         <= cos_next;
            sin_reg         <= sin_next;
            trig_sample_reg <= smp_reg[N-1];
            qc_reg          <= trig_sample_reg.q * cos_reg;
            is_reg          <= trig_sample_reg.i * sin_reg;
            out_demod_reg   <= demod_next;
        end
    end

    // Imaginary part of the derotated sample, rounded and saturated.
    always_comb
    begin
        dsum   = DW'(qc_reg) - DW'(is_reg) + D_HALF;
        dshift = dsum >>> TF;
        if (dshift > D_MAX)
        begin
            demod_next = DB'(D_MAX);
        end
        else if (dshift < D_MIN)
        begin
            demod_next = DB'(D_MIN);
        end
        else
        begin
            demod_next = DB'(dshift);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_demod = out_demod_reg;

endmodule

// ===== hw/rtl/ctpll_skid.sv =====
// ----------------------------------------------------------------------------
// Carrier tracking PLL output skid buffer
// Two-entry output stage. Its ready depends only on its own registers, so
// the downstream ready never reaches the upstream side combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctpll_skid (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic signed [ctpll_pkg::DEMOD_BITS-1:0] in_data,
    output logic                                    in_ready,
    output logic                                    out_valid,
    output logic signed [ctpll_pkg::DEMOD_BITS-1:0] out_data,
    input  logic                                    out_ready
);

    localparam int DB = ctpll_pkg::DEMOD_BITS;

    logic                   main_valid_reg;
    logic signed [DB-1:0]   main_data_reg;
    logic                   skid_valid_reg;
    logic signed [DB-1:0]   skid_data_reg;
    logic                   accept_in;
    logic                   main_free;

    assign in_ready  = !skid_valid_reg;
    assign accept_in = in_valid && !skid_valid_reg;
    assign main_free = !main_valid_reg || out_ready;

    // Occupancy control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || accept_in;
            skid_valid_reg <= 1'b0;
        end
        else if (accept_in)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Data movement; the skid entry drains first to keep order.
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (accept_in)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

// ===== hw/rtl/carrier_tracking_pll.sv =====
// ----------------------------------------------------------------------------
// Carrier tracking PLL
// Second-order phase-locked loop that tracks the carrier of a complex
// baseband stream and outputs the demodulated (derotated imaginary) value.
//
// Usage: one complex sample enters per word on the s_axis channel, and one
// demodulated value leaves per word on the m_axis channel, in order. A word
// can be accepted every cycle while the output is not stalled; each result is
// presented on m_axis after the angle pipeline, loop filter, derotator and
// output stage, and can be taken at the next rising edge. The phase and
// frequency update fixes the rate at one word per cycle; the angle and the
// sine and cosine are separate 16-stage CORDIC pipelines on either side of
// it. When m_axis_tready is low, the two-entry output stage fills and then
// the whole pipeline holds, so s_axis_tready drops; nothing is lost. Reset
// clears phase and frequency to zero, empties the pipeline and loads the
// default loop gains. Gains and the frequency limit are written over the APB
// port; the user writes them only while no word is in flight (not enforced).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "carrier_tracking_pll_defines.svh"

module carrier_tracking_pll (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Sample stream: [15:0] sample_i, [31:16] sample_q
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [2*ctpll_pkg::SAMPLE_BITS-1:0]     s_axis_tdata,
    // Result stream: [16:0] demod_value, [23:17] zero
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [23:0]                             m_axis_tdata,
    // Configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [ctpll_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [ctpll_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [ctpll_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                    pready
);

    localparam int PB = ctpll_pkg::PHASE_BITS;
    localparam int DB = ctpll_pkg::DEMOD_BITS;
    localparam int FB = ctpll_pkg::FREQ_BITS;
    localparam int AW = ctpll_pkg::APB_ADDR_BITS;
    localparam int DW = ctpll_pkg::APB_DATA_BITS;

    ctpll_pkg::cfg_t            cfg_reg;
    logic                       cfg_write;
    logic [AW-3:0]              reg_idx;

    logic                       pipe_en;
    ctpll_pkg::sample_t         in_sample;

    logic                       ang_valid;
    logic [PB-1:0]              ang_value;
    ctpll_pkg::sample_t         ang_sample;

    logic                       lp_valid;
    logic [PB-1:0]              lp_phase;
    ctpll_pkg::sample_t         lp_sample;
    ctpll_pkg::loop_state_t     loop_state;

    logic                       rot_valid;
    logic signed [DB-1:0]       rot_demod;

    logic                       skid_ready;
    logic signed [DB-1:0]       out_demod;
    logic signed [FB-1:0]       lim_s;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[AW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_gain      <= ctpll_pkg::PHASE_GAIN_RESET;
            cfg_reg.freq_gain       <= ctpll_pkg::FREQ_GAIN_RESET;
            cfg_reg.max_freq_offset <= ctpll_pkg::MAX_FREQ_OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                ctpll_pkg::REG_PHASE_GAIN:
                begin
                    cfg_reg.phase_gain <= pwdata[ctpll_pkg::GAIN_BITS-1:0];
                end
                ctpll_pkg::REG_FREQ_GAIN:
                begin
                    cfg_reg.freq_gain <= pwdata[ctpll_pkg::GAIN_BITS-1:0];
                end
                ctpll_pkg::REG_MAX_FREQ_OFFSET:
                begin
                    cfg_reg.max_freq_offset <= pwdata[ctpll_pkg::LIMIT_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_idx)
            ctpll_pkg::REG_PHASE_GAIN:      prdata = DW'(cfg_reg.phase_gain);
            ctpll_pkg::REG_FREQ_GAIN:       prdata = DW'(cfg_reg.freq_gain);
            ctpll_pkg::REG_MAX_FREQ_OFFSET: prdata = DW'(cfg_reg.max_freq_offset);
            default:                        prdata = '0;
        endcase
    end

    // The pipeline advances unless a finished word waits on a full output.
    assign pipe_en       = skid_ready || !rot_valid;
    assign s_axis_tready = pipe_en;
    assign in_sample     = s_axis_tdata;

    ctpll_vector u_vector (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .in_valid   (s_axis_tvalid),
        .in_sample  (in_sample),
        .out_valid  (ang_valid),
        .out_angle  (ang_value),
        .out_sample (ang_sample)
    );

    ctpll_loop u_loop (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .in_valid   (ang_valid),
        .in_angle   (ang_value),
        .in_sample  (ang_sample),
        .cfg        (cfg_reg),
        .out_valid  (lp_valid),
        .out_phase  (lp_phase),
        .out_sample (lp_sample),
        .state      (loop_state)
    );

    ctpll_rotator u_rotator (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .in_valid   (lp_valid),
        .in_phase   (lp_phase),
        .in_sample  (lp_sample),
        .out_valid  (rot_valid),
        .out_demod  (rot_demod)
    );

    ctpll_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rot_valid),
        .in_data    (rot_demod),
        .in_ready   (skid_ready),
        .out_valid  (m_axis_tvalid),
        .out_data   (out_demod),
        .out_ready  (m_axis_tready)
    );

    assign m_axis_tdata = 24'($unsigned(out_demod));

    // Frequency limit as a signed value for the checks below.
    assign lim_s = $signed(FB'(cfg_reg.max_freq_offset));

    // Oscillator state changes only when a word passes the loop stage.
    `CTPLL_ASSERT_NEXT(a_state_hold, !(pipe_en && ang_valid), $stable(loop_state),
        "oscillator state changed without a word")

    // After an update the frequency lies within the limit it was clipped to.
    `CTPLL_ASSERT_NEXT(a_freq_clip, pipe_en && ang_valid,
        (loop_state.freq <= $past(lim_s)) && (loop_state.freq >= -$past(lim_s)),
        "frequency outside the clip limit")

    // A finished word held back by a full output stage stays put.
    `CTPLL_ASSERT_NEXT(a_rot_hold, rot_valid && !skid_ready,
        rot_valid && $stable(rot_demod), "stalled result changed")

    // A zero sample measures as angle zero.
    `CTPLL_ASSERT_NOW(a_zero_angle,
        ang_valid && (ang_sample.i == '0) && (ang_sample.q == '0),
        ang_value == '0, "zero sample gave a nonzero angle")

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Carrier tracking PLL testbench
// Streams complex samples through the loop and compares every demodulated
// word against a bit-exact fixed-point loop predictor kept in a scoreboard.
// A directed set of corner samples runs first. Phases of carrier bursts,
// noise and corner values follow, under several gain settings and
// back-pressure patterns on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import ctpll_pkg::*;

    localparam longint TIMEOUT_NS = 4_000_000;
    localparam real    TWO_PI     = 6.283185307179586;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = REG_IDX_BITS'(3);

    // Arctangent of 2^-k as a 32-bit fraction of a turn.
    localparam longint ATAN_TURN [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245,
        2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    // Directed samples. The first one lands exactly half a turn from the
    // reset phase; the rest cover zero and the extremes of both fields.
    localparam int N_CORNERS = 21;
    localparam int CORNER_I [N_CORNERS] = '{
        -32767, 0, 32767, 0, -32768, 0, -32768, 32767, -32768, 32767,
        1, 0, -1, 1, -1, 0, 16384, -20000, 21845, -21846, -32768
    };
    localparam int CORNER_Q [N_CORNERS] = '{
        0, 0, 0, 32767, 0, -32768, -32768, 32767, 32767, -32768,
        0, 1, -1, -1, 1, 0, -16384, 12345, -21846, 21845, 1
    };

    typedef logic signed [DEMOD_BITS-1:0] demod_t;

    // ------------------------------------------------------------------------
    // Loop predictor and store of expected demodulated words.
    // ------------------------------------------------------------------------
    class demod_predictor;
        logic [GAIN_BITS-1:0]  phase_gain;
        logic [GAIN_BITS-1:0]  freq_gain;
        logic [LIMIT_BITS-1:0] max_freq_offset;
        logic [PHASE_BITS-1:0] osc_phase;
        longint                osc_freq;
        demod_t                demod_due[$];
        int                    mismatches;
        int                    words_checked;
        int                    samples_in;
        int                    limit_hits;
        int                    half_turns;
        int                    zero_samples;

        function new();
            phase_gain      = PHASE_GAIN_RESET;
            freq_gain       = FREQ_GAIN_RESET;
            max_freq_offset = MAX_FREQ_OFFSET_RESET;
            osc_phase       = '0;
            osc_freq        = 0;
        endfunction

        function longint clamp(input longint v, input longint lo, input longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void write_reg(input logic [REG_IDX_BITS-1:0] idx,
                                input logic [APB_DATA_BITS-1:0] value);
            case (idx)
                REG_PHASE_GAIN:      phase_gain = value[GAIN_BITS-1:0];
                REG_FREQ_GAIN:       freq_gain = value[GAIN_BITS-1:0];
                REG_MAX_FREQ_OFFSET: max_freq_offset = value[LIMIT_BITS-1:0];
                default:             ;
            endcase
        endfunction

        // Works out the demodulated word for one sample, then steps the loop.
        function void accept_sample(input sample_t smp);
            longint si, sq, x, y, xs, ys, zs, c, s, d, err, pg, fg, lim;
            logic [ANGLE_BITS-1:0] z, ang;
            logic [PHASE_BITS-1:0] e16;
            bit flip;
            int k;
            si = smp.i;
            sq = smp.q;

            // Cosine and sine of the oscillator phase by CORDIC rotation.
            // Phases in the left half-plane are rotated by half a turn first.
            z = {osc_phase, {(ANGLE_BITS - PHASE_BITS){1'b0}}};
            flip = (z[31:30] == 2'b01) || (z[31:30] == 2'b10);
            if (flip)
                z = z - HALF_TURN;
            zs = $signed(z);
            x = ROT_START;
            y = 0;
            for (k = 0; k < CORDIC_STEPS; k++)
            begin
                xs = x >>> k;
                ys = y >>> k;
                if (zs >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    zs = zs - ATAN_TURN[k];
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    zs = zs + ATAN_TURN[k];
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            c = clamp((x + 16384) >>> TRIG_FRAC, -32768, 32767);
            s = clamp((y + 16384) >>> TRIG_FRAC, -32768, 32767);
            d = clamp((sq * c - si * s + 16384) >>> TRIG_FRAC, -65536, 65535);
            demod_due.push_back(d[DEMOD_BITS-1:0]);

            // Angle of the sample by CORDIC vectoring on the scaled-up sample.
            // A sample with both parts zero has angle zero.
            ang = '0;
            if (si != 0 || sq != 0)
            begin
                x = si * 256;
                y = sq * 256;
                if (x < 0)
                begin
                    x = -x;
                    y = -y;
                    ang = HALF_TURN;
                end
                for (k = 0; k < CORDIC_STEPS; k++)
                begin
                    xs = x >>> k;
                    ys = y >>> k;
                    if (y > 0)
                    begin
                        x = x + ys;
                        y = y - xs;
                        ang = ang + ATAN_TURN[k];
                    end
                    else
                    begin
                        x = x - ys;
                        y = y + xs;
                        ang = ang - ATAN_TURN[k];
                    end
                end
            end
            else
                zero_samples++;

            // Phase error, wrapped so that exactly half a turn is negative.
            ang = ang + PHASE_ROUND;
            e16 = ang[ANGLE_BITS-1 -: PHASE_BITS] - osc_phase;
            err = $signed(e16);
            if (e16 == 16'h8000)
                half_turns++;

            // Frequency integrates the error and is clipped symmetrically.
            pg = phase_gain;
            fg = freq_gain;
            lim = max_freq_offset;
            osc_freq = osc_freq + ((err * fg + 32768) >>> 16);
            if (osc_freq > lim || osc_freq < -lim)
            begin
                limit_hits++;
                osc_freq = clamp(osc_freq, -lim, lim);
            end
            osc_phase = osc_phase + PHASE_BITS'((err * pg + 32768) >>> 16)
                      + PHASE_BITS'(osc_freq);
            samples_in++;
        endfunction

        function void check_demod(input logic [23:0] word);
            demod_t got, want;
            got = word[DEMOD_BITS-1:0];
            words_checked++;
            if (word[23:DEMOD_BITS] !== '0)
            begin
                $error("pad mismatch: expected 0, actual %0h", word[23:DEMOD_BITS]);
                mismatches++;
            end
            if (demod_due.size() == 0)
            begin
                $error("demod_value mismatch: expected no word, actual %0d", got);
                mismatches++;
                return;
            end
            want = demod_due.pop_front();
            if (got !== want)
            begin
                $error("demod_value mismatch: expected %0d, actual %0d", want, got);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test and its drive signals.
    // ------------------------------------------------------------------------
    logic                         clk;
    logic                         rst_n;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [2*SAMPLE_BITS-1:0]     s_axis_tdata;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [23:0]                  m_axis_tdata;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [APB_ADDR_BITS-1:0]     paddr;
    logic [APB_DATA_BITS-1:0]     pwdata;
    logic [APB_DATA_BITS-1:0]     prdata;
    logic                         pready;

    demod_predictor predictor;
    int src_idle_pct;
    int sink_stall_pct;
    bit hold_request;
    int hold_left;
    int input_stalls;
    int settings_used;

    carrier_tracking_pll i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #(TIMEOUT_NS);
        $display("testbench NOT OK");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else
                m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Result checking and input back-pressure count at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                predictor.check_demod(m_axis_tdata);
            if (s_axis_tvalid && !s_axis_tready)
                input_stalls++;
        end
    end

    // ------------------------------------------------------------------------
    // Drive tasks.
    // ------------------------------------------------------------------------
    function automatic logic signed [SAMPLE_BITS-1:0] to_sample(input int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return SAMPLE_BITS'(v);
    endfunction

    task automatic apb_write(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [APB_DATA_BITS-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        predictor.write_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_loop_gains(input int pg, input int fg, input int lim);
        apb_write(REG_PHASE_GAIN, pg);
        apb_write(REG_FREQ_GAIN, fg);
        apb_write(REG_MAX_FREQ_OFFSET, lim);
        settings_used++;
    endtask

    // Offers one sample, with random idle cycles ahead of it.
    task automatic push_sample(input int si, input int sq);
        sample_t smp;
        smp.i = to_sample(si);
        smp.q = to_sample(sq);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = smp;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predictor.accept_sample(smp);
        @(negedge clk);
    endtask

    // Stops offering and waits until every expected word has come back.
    task automatic drain_loop(input int tail);
        s_axis_tvalid = 1'b0;
        while (predictor.demod_due.size() != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    // Mostly carrier bursts with random offset, amplitude, noise and optional
    // sign flips; the rest is full-range noise and corner values.
    task automatic run_phase(input int n, input int src_idle, input int sink_stall,
                             input bit pressure);
        real theta, step, amp, sgn;
        int burst_left, kind, noise, si, sq, cnt;
        int corner [5];
        corner = '{-32768, -1, 0, 1, 32767};
        src_idle_pct = src_idle;
        sink_stall_pct = sink_stall;
        theta = 0.0;
        step = 0.0;
        amp = 0.0;
        burst_left = 0;
        kind = 0;
        noise = 0;
        for (cnt = 0; cnt < n; cnt++)
        begin
            if (pressure && cnt == 40)
                hold_request = 1'b1;
            if (burst_left == 0)
            begin
                kind = $urandom_range(9);
                burst_left = $urandom_range(8, 64);
                amp = ($urandom_range(3) == 0) ? 32767.0 : real'($urandom_range(1, 32767));
                step = TWO_PI * real'(int'($urandom_range(6000)) - 3000) / 65536.0;
                noise = $urandom_range(2000);
            end
            burst_left--;
            if (kind <= 6)
            begin
                theta = theta + step;
                sgn = (kind >= 5 && $urandom_range(1) == 1) ? -1.0 : 1.0;
                si = int'(sgn * amp * $cos(theta)) + int'($urandom_range(2 * noise)) - noise;
                sq = int'(sgn * amp * $sin(theta)) + int'($urandom_range(2 * noise)) - noise;
            end
            else if (kind <= 8)
            begin
                si = $signed(16'($urandom));
                sq = $signed(16'($urandom));
            end
            else
            begin
                si = corner[$urandom_range(4)];
                sq = corner[$urandom_range(4)];
            end
            push_sample(si, sq);
        end
        drain_loop(8);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        predictor      = new();
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_request   = 1'b0;
        hold_left      = 0;
        input_stalls   = 0;
        settings_used  = 1;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Corner samples under the reset gains.
        for (int n = 0; n < N_CORNERS; n++)
            push_sample(CORNER_I[n], CORNER_Q[n]);
        drain_loop(8);

        // Moderate gains, no idling, and one long receiver hold-off.
        load_loop_gains(8000, 400, 3000);
        run_phase(240, 0, 0, 1'b1);

        // Largest gains and limit; frequency runs into the clip often.
        load_loop_gains(65535, 65535, 32767);
        run_phase(240, 86, 0, 1'b0);

        // Zero gains and zero limit, plus a write to the unused index.
        load_loop_gains(0, 0, 0);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        run_phase(240, 0, 86, 1'b0);

        load_loop_gains($urandom_range(65535), $urandom_range(65535),
                        $urandom_range(32767));
        run_phase(240, 11, 11, 1'b0);

        load_loop_gains(PHASE_GAIN_RESET, FREQ_GAIN_RESET, MAX_FREQ_OFFSET_RESET);
        run_phase(240, 0, 0, 1'b0);

        load_loop_gains($urandom_range(20000), $urandom_range(4000), $urandom_range(32767));
        run_phase(240, 11, 11, 1'b0);

        drain_loop(60);

        $display("Checked %0d demodulated words from %0d samples under %0d loop settings.",
                 predictor.words_checked, predictor.samples_in, settings_used);
        $display("Frequency clipped %0d times, %0d half-turn errors, %0d zero samples, %0d stalls.",
                 predictor.limit_hits, predictor.half_turns, predictor.zero_samples,
                 input_stalls);
        if (predictor.mismatches == 0 && predictor.demod_due.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== carrier_tracking_pll.f =====
+incdir+hw/rtl
hw/rtl/ctpll_pkg.sv
hw/rtl/ctpll_vector.sv
hw/rtl/ctpll_loop.sv
hw/rtl/ctpll_rotator.sv
hw/rtl/ctpll_skid.sv
hw/rtl/carrier_tracking_pll.sv
sim/testbench.sv
